[hw/rtl/pat_pkg.sv]
// Package for the peer address table: field widths, operation, result-kind
// and status codes, sequencer states and the result record.
// No dependencies.
package pat_pkg;

  localparam int ADDR_W = 32;
  localparam int CNT_W  = 6;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_EMIT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ENTRY  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_MISSING = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_STATUS,
    S_HEADER,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic [ADDR_W-1:0]  payload;
    status_t            status;
    logic               found;
    logic [CNT_W-1:0]   count;
    logic               last;
  } res_t;

endpackage

[hw/rtl/pat_engine.sv]
// Table sequencer for the peer address table: entry memory with registered
// read, search, compaction and list emission.
// Depends on pat_pkg.
module pat_engine #(
  parameter int CAPACITY = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pat_pkg::op_t              in_op,
  input  logic [pat_pkg::ADDR_W-1:0] in_addr,
  input  logic                      out_free,
  output logic                      res_load,
  output pat_pkg::res_t             res
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [pat_pkg::CNT_W-1:0] CAP = pat_pkg::CNT_W'(CAPACITY);

  logic [pat_pkg::ADDR_W-1:0] mem [CAPACITY];
  logic [pat_pkg::ADDR_W-1:0] rdata;
  logic                       rd_en;
  logic [IDX_W-1:0]           rd_idx;
  logic                       we;
  logic [IDX_W-1:0]           wr_idx;
  logic [pat_pkg::ADDR_W-1:0] wr_data;

  pat_pkg::state_t            state, state_next;
  pat_pkg::op_t               op, op_next;
  logic [pat_pkg::ADDR_W-1:0] addr, addr_next;
  logic [pat_pkg::CNT_W-1:0]  idx, idx_next, idx_inc;
  logic [pat_pkg::CNT_W-1:0]  count, count_next;
  pat_pkg::status_t           status, status_next;
  logic                       found, found_next;

  assign idx_inc = idx + pat_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pat_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    op     <= op_next;
    addr   <= addr_next;
    idx    <= idx_next;
    status <= status_next;
    found  <= found_next;
  end

  always_comb begin
    state_next  = state;
    op_next     = op;
    addr_next   = addr;
    idx_next    = idx;
    count_next  = count;
    status_next = status;
    found_next  = found;
    in_ready    = 1'b0;
    rd_en       = 1'b0;
    rd_idx      = idx[IDX_W-1:0];
    we          = 1'b0;
    wr_idx      = idx[IDX_W-1:0];
    wr_data     = addr;
    res_load    = 1'b0;
    res.kind    = pat_pkg::KIND_STATUS;
    res.payload = '0;
    res.status  = status;
    res.found   = found;
    res.count   = count;
    res.last    = 1'b1;

    case (state)
      pat_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_next     = in_op;
          addr_next   = in_addr;
          idx_next    = '0;
          status_next = pat_pkg::STATUS_OK;
          found_next  = 1'b0;
          case (in_op)
            pat_pkg::OP_ADD:    state_next = pat_pkg::S_ADD;
            pat_pkg::OP_REMOVE: state_next = pat_pkg::S_SRCH_RD;
            pat_pkg::OP_QUERY:  state_next = pat_pkg::S_SRCH_RD;
            default:            state_next = pat_pkg::S_HEADER;
          endcase
        end
      end

      pat_pkg::S_ADD: begin
        if (count >= CAP) begin
          status_next = pat_pkg::STATUS_FULL;
        end else begin
          we         = 1'b1;
          wr_idx     = count[IDX_W-1:0];
          count_next = count + pat_pkg::CNT_W'(1);
        end
        state_next = pat_pkg::S_STATUS;
      end

      pat_pkg::S_SRCH_RD: begin
        if (idx >= count) begin
          if (op == pat_pkg::OP_REMOVE) begin
            status_next = pat_pkg::STATUS_MISSING;
          end
          state_next = pat_pkg::S_STATUS;
        end else begin
          rd_en      = 1'b1;
          state_next = pat_pkg::S_SRCH_CMP;
        end
      end

      pat_pkg::S_SRCH_CMP: begin
        if (rdata == addr) begin
          if (op == pat_pkg::OP_REMOVE) begin
            state_next = pat_pkg::S_SHIFT_RD;
          end else begin
            found_next = 1'b1;
            state_next = pat_pkg::S_STATUS;
          end
        end else begin
          idx_next   = idx_inc;
          state_next = pat_pkg::S_SRCH_RD;
        end
      end

      pat_pkg::S_SHIFT_RD: begin
        if (idx_inc >= count) begin
          count_next = count - pat_pkg::CNT_W'(1);
          state_next = pat_pkg::S_STATUS;
        end else begin
          rd_en      = 1'b1;
          rd_idx     = idx_inc[IDX_W-1:0];
          state_next = pat_pkg::S_SHIFT_WR;
        end
      end

      pat_pkg::S_SHIFT_WR: begin
        we         = 1'b1;
        wr_data    = rdata;
        idx_next   = idx_inc;
        state_next = pat_pkg::S_SHIFT_RD;
      end

      pat_pkg::S_STATUS: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = pat_pkg::S_IDLE;
        end
      end

      pat_pkg::S_HEADER: begin
        res.kind    = pat_pkg::KIND_HEADER;
        res.payload = pat_pkg::ADDR_W'(count);
        res.last    = (count == '0);
        if (out_free) begin
          res_load   = 1'b1;
          state_next = (count == '0) ? pat_pkg::S_IDLE : pat_pkg::S_EMIT_RD;
        end
      end

      pat_pkg::S_EMIT_RD: begin
        rd_en      = 1'b1;
        state_next = pat_pkg::S_EMIT_OUT;
      end

      pat_pkg::S_EMIT_OUT: begin
        res.kind    = pat_pkg::KIND_ENTRY;
        res.payload = rdata;
        res.last    = (idx_inc == count);
        if (out_free) begin
          res_load   = 1'b1;
          idx_next   = idx_inc;
          state_next = (idx_inc == count) ? pat_pkg::S_IDLE : pat_pkg::S_EMIT_RD;
        end
      end

      default: begin
        state_next = pat_pkg::S_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP)
    else $error("entry count above capacity");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (pat_pkg::CNT_W'(wr_idx) < count || state == pat_pkg::S_ADD))
    else $error("write outside held entries");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("result loaded into busy output stage");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state != pat_pkg::S_IDLE)
    else $error("accepted transaction not started");

endmodule

[hw/rtl/peer_address_table.sv]
// Peer address table: stream in one operation per transaction, stream out
// status, or a list message of header plus one transaction per entry.
// Ports: slave side s_axis_* carries the operation, master side m_axis_*
// carries results. Depends on pat_pkg and pat_engine.
// One operation is worked at a time; s_axis_tready is high only while the
// sequencer is idle, even if a result still waits in the output register.
// Steps per operation: add writes the new entry at the end of the table,
//   or reports full; query and remove read and then compare each entry from
//   the first until a match or the end; remove then moves each later entry
//   down one place, a read and then a write; emit sends the header, then
//   reads and sends each entry in turn. The entry memory's single read port
//   with its registered read sets this read-then-use order.
// Results leave through one output register; while m_axis_tready is low the
// result holds and the sequencer waits before loading the next one.
// Reset empties the table at once (entry count cleared); no clearing pass.
module peer_address_table #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // addr[31:0]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // payload[31:0], status[33:32], found[34],
                                      // count[40:35], zero[47:41]
  output logic [1:0]  m_axis_tuser,   // kind[1:0]
  output logic        m_axis_tlast
);

  logic          out_free;
  logic          res_load;
  pat_pkg::res_t res;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  pat_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (pat_pkg::op_t'(s_axis_tuser)),
    .in_addr  (s_axis_tdata),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_axis_tdata <= {7'd0, res.count, res.found, res.status, res.payload};
      m_axis_tuser <= res.kind;
      m_axis_tlast <= res.last;
    end
  end

endmodule

[test/peer_address_table_checker.sv]
// Scoreboard for the peer address table: watches the operation and result streams,
// keeps its own copy of the table and compares every result transaction in order.
// Depends on pat_pkg.
module peer_address_table_checker #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // addr[31:0]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // payload[31:0], status[33:32], found[34],
                                      // count[40:35], zero[47:41]
  input  logic [1:0]  m_axis_tuser,   // kind[1:0]
  input  logic        m_axis_tlast,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [pat_pkg::ADDR_W-1:0] peers [CAPACITY];
  int                         n_peers;
  pat_pkg::res_t              expected_results [$];

  function automatic pat_pkg::res_t make_result(pat_pkg::kind_t kind,
                                                logic [pat_pkg::ADDR_W-1:0] payload,
                                                pat_pkg::status_t status,
                                                logic found, logic last);
    pat_pkg::res_t r;
    r.kind    = kind;
    r.payload = payload;
    r.status  = status;
    r.found   = found;
    r.count   = pat_pkg::CNT_W'(n_peers);
    r.last    = last;
    return r;
  endfunction

  task automatic predict_transaction(pat_pkg::op_t op, logic [pat_pkg::ADDR_W-1:0] a);
    int hit;
    hit = -1;
    for (int i = n_peers - 1; i >= 0; i--)
      if (peers[i] == a) hit = i;
    case (op)
      pat_pkg::OP_ADD: begin
        if (n_peers >= CAPACITY) begin
          expected_results.push_back(make_result(pat_pkg::KIND_STATUS, '0,
                                                 pat_pkg::STATUS_FULL, 1'b0, 1'b1));
        end else begin
          peers[n_peers] = a;
          n_peers++;
          expected_results.push_back(make_result(pat_pkg::KIND_STATUS, '0,
                                                 pat_pkg::STATUS_OK, 1'b0, 1'b1));
        end
      end
      pat_pkg::OP_REMOVE: begin
        if (hit < 0) begin
          expected_results.push_back(make_result(pat_pkg::KIND_STATUS, '0,
                                                 pat_pkg::STATUS_MISSING, 1'b0, 1'b1));
        end else begin
          for (int i = hit; i < n_peers - 1; i++)
            peers[i] = peers[i + 1];
          n_peers--;
          expected_results.push_back(make_result(pat_pkg::KIND_STATUS, '0,
                                                 pat_pkg::STATUS_OK, 1'b0, 1'b1));
        end
      end
      pat_pkg::OP_QUERY: begin
        expected_results.push_back(make_result(pat_pkg::KIND_STATUS, '0,
                                               pat_pkg::STATUS_OK, hit >= 0, 1'b1));
      end
      default: begin
        expected_results.push_back(make_result(pat_pkg::KIND_HEADER,
                                               pat_pkg::ADDR_W'(n_peers),
                                               pat_pkg::STATUS_OK, 1'b0, n_peers == 0));
        for (int i = 0; i < n_peers; i++)
          expected_results.push_back(make_result(pat_pkg::KIND_ENTRY, peers[i],
                                                 pat_pkg::STATUS_OK, 1'b0,
                                                 i == n_peers - 1));
      end
    endcase
  endtask

  always @(posedge clk) begin
    pat_pkg::res_t got;
    pat_pkg::res_t want;
    if (rst) begin
      n_peers    = 0;
      mismatches = 0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind    = pat_pkg::kind_t'(m_axis_tuser);
        got.payload = m_axis_tdata[31:0];
        got.status  = pat_pkg::status_t'(m_axis_tdata[33:32]);
        got.found   = m_axis_tdata[34];
        got.count   = m_axis_tdata[40:35];
        got.last    = m_axis_tlast;
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: kind=%0d payload=%h last=%b",
                   $time, got.kind, got.payload, got.last);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.payload !== want.payload ||
              got.status !== want.status || got.found !== want.found ||
              got.count !== want.count || got.last !== want.last) begin
            $display("%0t: expected kind=%0d payload=%h status=%0d found=%b count=%0d last=%b",
                     $time, want.kind, want.payload, want.status, want.found, want.count,
                     want.last);
            $display("%0t:   actual kind=%0d payload=%h status=%0d found=%b count=%0d last=%b",
                     $time, got.kind, got.payload, got.status, got.found, got.count,
                     got.last);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_transaction(pat_pkg::op_t'(s_axis_tuser), s_axis_tdata);
    end
    outstanding = expected_results.size();
  end

endmodule

[test/peer_address_table_tb.sv]
// Testbench top for the peer address table: clock, reset, operation stimulus,
// result back-pressure and the verdict. Depends on pat_pkg,
// peer_address_table and peer_address_table_checker.
module peer_address_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 32;
  localparam int PHASE_ITEMS = 125;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = pat_pkg::OP_ADD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int          mismatches;
  int          outstanding;
  int          tx_idle_pct   = 0;
  int          rx_stall_pct  = 0;
  int          hold_requests = 0;
  int          holds_served  = 0;
  int          hold_left     = 0;
  logic [31:0] addr_pool [8];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  peer_address_table #(.CAPACITY(TABLE_DEPTH)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  peer_address_table_checker #(.CAPACITY(TABLE_DEPTH)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // Hold off results for a long stretch on request, else stall at random.
  always @(negedge clk) begin
    if (hold_left == 0 && holds_served != hold_requests) begin
      holds_served++;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_op(pat_pkg::op_t op, logic [31:0] a);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= a;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic pat_pkg::op_t pick_op(int add_pct, int remove_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < add_pct) return pat_pkg::OP_ADD;
    if (roll < add_pct + remove_pct) return pat_pkg::OP_REMOVE;
    if (roll < 92) return pat_pkg::OP_QUERY;
    return pat_pkg::OP_EMIT;
  endfunction

  function automatic logic [31:0] pick_addr();
    if ($urandom_range(99) < 70) return addr_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  initial begin
    int add_pct [4];
    int remove_pct [4];
    int idle_pct [4];
    int stall_pct [4];
    pat_pkg::op_t op;
    add_pct    = '{60, 25, 40, 55};
    remove_pct = '{20, 50, 35, 25};
    idle_pct   = '{0, 45, 0, 28};
    stall_pct  = '{0, 0, 45, 28};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_op(pat_pkg::OP_EMIT,   32'h0000_0000);
    send_op(pat_pkg::OP_REMOVE, 32'h0000_0000);
    send_op(pat_pkg::OP_QUERY,  32'h0000_0000);
    send_op(pat_pkg::OP_ADD,    32'h0000_0000);
    send_op(pat_pkg::OP_ADD,    32'hFFFF_FFFF);
    send_op(pat_pkg::OP_ADD,    32'h0000_0000);
    send_op(pat_pkg::OP_ADD,    32'hA5A5_A5A5);
    send_op(pat_pkg::OP_QUERY,  32'h0000_0000);
    send_op(pat_pkg::OP_QUERY,  32'hFFFF_FFFF);
    send_op(pat_pkg::OP_QUERY,  32'h1234_5678);
    send_op(pat_pkg::OP_EMIT,   32'h0000_0000);
    send_op(pat_pkg::OP_REMOVE, 32'h0000_0000);
    send_op(pat_pkg::OP_EMIT,   32'hFFFF_FFFF);
    send_op(pat_pkg::OP_REMOVE, 32'h5A5A_5A5A);
    send_op(pat_pkg::OP_REMOVE, 32'hFFFF_FFFF);
    send_op(pat_pkg::OP_REMOVE, 32'hA5A5_A5A5);
    send_op(pat_pkg::OP_REMOVE, 32'h0000_0000);
    send_op(pat_pkg::OP_EMIT,   32'h0000_0000);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      tx_idle_pct  = idle_pct[phase];
      rx_stall_pct = stall_pct[phase];
      addr_pool[0] = 32'h0000_0000;
      addr_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 8; i++)
        addr_pool[i] = $urandom;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        op = pick_op(add_pct[phase], remove_pct[phase]);
        if (phase == 3 && k == 40) begin
          hold_requests++;
          op = pat_pkg::OP_EMIT;
        end
        send_op(op, pick_addr());
      end
      wait_drained();
    end

    repeat (80) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("peer_address_table: match");
    else
      $display("peer_address_table: mismatch");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("peer_address_table: mismatch");
    $finish;
  end

endmodule
